### hdl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
    localparam logic [7:0]  CHAR_CR        = 8'h0d;
    localparam logic [7:0]  CHAR_LF        = 8'h0a;

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_LF   = 3'd1,
        PH_DATA = 3'd2,
        PH_TRL1 = 3'd3,
        PH_TRL2 = 3'd4,
        PH_HALT = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_BIG  = 2'd3
    } t_status;

    typedef struct packed {
        logic       start_message;
        logic [7:0] octet_in;
    } t_item;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] octet_out;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

### hdl/hcbd_if.sv
// ----------------------------------------------------------------------------
// hcbd_if
// Valid/ready channels for raw input items and decoded result items.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       start_message;
    logic [7:0] octet_in;

    modport source (output valid, output start_message, output octet_in, input ready);
    modport sink   (input valid, input start_message, input octet_in, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] octet_out;
    logic [1:0] status;

    modport source (output valid, output data_valid, output octet_out, output status,
                    input ready);
    modport sink   (input valid, input data_valid, input octet_out, input status,
                    output ready);
endinterface

### hdl/hcbd_in_reg.sv
// ----------------------------------------------------------------------------
// hcbd_in_reg
// Input register stage holding one raw item for the decode step.
// ----------------------------------------------------------------------------
module hcbd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hcbd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_valid,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### hdl/hcbd_core.sv
// ----------------------------------------------------------------------------
// hcbd_core
// Chunk framing state machine: size line parse, payload pass, trailer skip.
// ----------------------------------------------------------------------------
module hcbd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  hcbd_pkg::t_item  i_item,
    input  logic [31:0]      i_max_body_size,
    output hcbd_pkg::t_result o_res
);
    import hcbd_pkg::*;

    t_phase      r_phase, n_phase, c_phase;
    t_status     r_outcome, n_outcome, c_outcome;
    logic [31:0] r_accum, n_accum, c_accum;
    logic [31:0] r_left, n_left, c_left;
    logic [32:0] r_total, n_total, c_total;
    logic [32:0] sum_total;
    logic [31:0] left_dec;
    t_hex        hex;

    // start of message clears state before the byte is handled
    always_comb begin
        if (i_item.start_message) begin
            c_phase   = PH_SIZE;
            c_outcome = ST_RUN;
            c_accum   = '0;
            c_left    = '0;
            c_total   = '0;
        end else begin
            c_phase   = r_phase;
            c_outcome = r_outcome;
            c_accum   = r_accum;
            c_left    = r_left;
            c_total   = r_total;
        end
    end

    assign hex       = hex_decode(i_item.octet_in);
    assign sum_total = c_total + {1'b0, c_accum};
    assign left_dec  = c_left - 32'd1;

    // next state
    always_comb begin
        n_phase   = c_phase;
        n_outcome = c_outcome;
        n_accum   = c_accum;
        n_left    = c_left;
        n_total   = c_total;
        if (c_outcome == ST_RUN) begin
            case (c_phase)
                PH_SIZE: begin
                    if (i_item.octet_in == CHAR_CR) begin
                        n_phase = PH_LF;
                    end else if (!hex.ok) begin
                        n_outcome = ST_BAD;
                        n_phase   = PH_HALT;
                    end else if (c_accum[31:28] != 4'd0) begin
                        n_outcome = ST_BIG;
                        n_phase   = PH_HALT;
                    end else begin
                        n_accum = {c_accum[27:0], hex.value};
                    end
                end
                PH_LF: begin
                    if (i_item.octet_in == CHAR_LF) begin
                        n_total = sum_total;
                        if (sum_total > {1'b0, i_max_body_size}) begin
                            n_outcome = ST_BIG;
                            n_phase   = PH_HALT;
                        end else if (c_accum == 32'd0) begin
                            n_outcome = ST_DONE;
                            n_phase   = PH_HALT;
                        end else begin
                            n_left  = c_accum;
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_outcome = ST_BAD;
                        n_phase   = PH_HALT;
                    end
                end
                PH_DATA: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase = PH_TRL1;
                    end
                end
                PH_TRL1: begin
                    n_phase = PH_TRL2;
                end
                PH_TRL2: begin
                    n_accum = '0;
                    n_phase = PH_SIZE;
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res.data_valid = 1'b0;
        o_res.octet_out  = 8'd0;
        o_res.status     = n_outcome;
        case (c_phase)
            PH_DATA: begin
                if (c_outcome == ST_RUN) begin
                    o_res.data_valid = 1'b1;
                    o_res.octet_out  = i_item.octet_in;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE;
            r_outcome <= ST_RUN;
            r_accum   <= '0;
            r_left    <= '0;
            r_total   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_outcome <= n_outcome;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_total   <= n_total;
        end
    end

endmodule

### hdl/hcbd_out_reg.sv
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  hcbd_pkg::t_result i_res,
    output logic              o_free,
    hcbd_out_if.source        o_out
);
    import hcbd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free          = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.data_valid = r_res.data_valid;
    assign o_out.octet_out  = r_res.octet_out;
    assign o_out.status     = r_res.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### hdl/http_chunked_body_decoder_top.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Chunked transfer body decoder, one raw byte in and one result item out.
//
//   port    dir  contents
//   i_in    in   start_message, octet_in
//   o_out   out  data_valid, octet_out, status
//   i_cfg   in   max_body_size write (i_cfg_we, i_cfg_wdata)
//
// one item per cycle unless the output stalls; items pass the input register
// and result register, with the framing state updated between them
// reset is synchronous and active low, no clearing pass
// a stalled output holds its item; input keeps flowing while stages are free
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import hcbd_pkg::*;

    logic [31:0] r_max_body;
    t_item       in_item;
    t_item       stg_item;
    t_result     core_res;
    logic        stg_valid;
    logic        out_free;
    logic        fire;

    assign in_item.start_message = i_in.start_message;
    assign in_item.octet_in      = i_in.octet_in;
    assign fire                  = stg_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            r_max_body <= i_cfg_wdata;
        end
    end

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .i_take  (fire),
        .o_ready (i_in.ready),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    hcbd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_item          (stg_item),
        .i_max_body_size (r_max_body),
        .o_res           (core_res)
    );

    hcbd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

### hdl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_data_valid,
    input logic [7:0] i_octet_out,
    input logic [1:0] i_status
);
    import hcbd_pkg::*;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result channel not empty after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result item dropped");

    a_data_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_data_valid |-> i_status == ST_RUN)
        else $error("payload byte after message outcome");

    a_idle_octet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_octet_out == 8'd0)
        else $error("octet_out not zero without payload");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_valid (o_out.data_valid),
    .i_octet_out  (o_out.octet_out),
    .i_status     (o_out.status)
);

### sim/hcbd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_result_checker
// Watches the byte and result channels of the chunked body decoder, decodes
// every accepted byte itself and compares each result item field by field
// with the oldest decoded expectation.
// ----------------------------------------------------------------------------
module hcbd_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if          i_in,
    hcbd_out_if         i_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    import hcbd_pkg::*;

    logic [31:0] body_limit;
    t_phase      phase;
    logic [31:0] size_accum;
    logic [31:0] bytes_left;
    logic [32:0] size_total;
    t_status     outcome;
    t_result     pending_results[$];
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("%0t mismatch: %s", $time, msg);
        end
        fail_count = fail_count + 1;
    endtask

    task automatic clear_decoder();
        phase      = PH_SIZE;
        size_accum = '0;
        bytes_left = '0;
        size_total = '0;
        outcome    = ST_RUN;
    endtask

    task automatic halt_with(input t_status code);
        outcome = code;
        phase   = PH_HALT;
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    task automatic decode_octet(input logic start, input logic [7:0] c, output t_result r);
        int d;
        r = '0;
        if (start) begin
            clear_decoder();
        end
        if (outcome == ST_RUN) begin
            case (phase)
                PH_SIZE: begin
                    if (c == CHAR_CR) begin
                        phase = PH_LF;
                    end else begin
                        d = hex_digit(c);
                        if (d < 0) begin
                            halt_with(ST_BAD);
                        end else if (size_accum > 32'h0fff_ffff) begin
                            halt_with(ST_BIG);
                        end else begin
                            size_accum = {size_accum[27:0], d[3:0]};
                        end
                    end
                end
                PH_LF: begin
                    if (c == CHAR_LF) begin
                        size_total = size_total + {1'b0, size_accum};
                        if (size_total > {1'b0, body_limit}) begin
                            halt_with(ST_BIG);
                        end else if (size_accum == 32'd0) begin
                            halt_with(ST_DONE);
                        end else begin
                            bytes_left = size_accum;
                            phase      = PH_DATA;
                        end
                    end else begin
                        halt_with(ST_BAD);
                    end
                end
                PH_DATA: begin
                    r.data_valid = 1'b1;
                    r.octet_out  = c;
                    bytes_left   = bytes_left - 32'd1;
                    if (bytes_left == 32'd0) begin
                        phase = PH_TRL1;
                    end
                end
                PH_TRL1: begin
                    phase = PH_TRL2;
                end
                PH_TRL2: begin
                    size_accum = '0;
                    phase      = PH_SIZE;
                end
                default: begin
                end
            endcase
        end
        r.status = outcome;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            body_limit = MAX_BODY_RESET;
            clear_decoder();
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.data_valid = i_out.data_valid;
                got.octet_out  = i_out.octet_out;
                got.status     = i_out.status;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected item dv=%0d octet=%02h status=%0d",
                                              got.data_valid, got.octet_out, got.status));
                end else begin
                    want = pending_results.pop_front();
                    if (got.data_valid !== want.data_valid) begin
                        report_mismatch($sformatf("data_valid %0d, wanted %0d",
                                                  got.data_valid, want.data_valid));
                    end
                    if (got.octet_out !== want.octet_out) begin
                        report_mismatch($sformatf("octet_out %02h, wanted %02h",
                                                  got.octet_out, want.octet_out));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  got.status, want.status));
                    end
                end
            end
            if (i_cfg_we) begin
                body_limit = i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                decode_octet(i_in.start_message, i_in.octet_in, predicted);
                pending_results.push_back(predicted);
            end
        end
        pending_count <= pending_results.size();
    end

endmodule

### sim/http_chunked_body_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_test
// Drives chunked bodies into the decoder: a few hand-picked messages, then
// random well-formed, malformed and oversized messages under several body
// limits and idling patterns; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top_test;
    import hcbd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          items_sent    = 0;
    logic        message_head  = 1'b1;
    logic [31:0] body_limits [4] = '{32'hffff_ffff, 32'd0, 32'd20, MAX_BODY_RESET};

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    hcbd_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // long hold-off when requested, random idling otherwise
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready  <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen     <= hold_requests;
            hold_left     <= 400;
            out_ch.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready  <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 10) begin
            return 8'h30 + n;
        end
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] junk_octet();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                   (b >= "a" && b <= "f") || b == CHAR_CR);
        return b;
    endfunction

    task automatic send_item(input logic start, input logic [7:0] octet);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.start_message <= start;
        in_ch.octet_in      <= octet;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic send_octet(input logic [7:0] b);
        send_item(message_head, b);
        message_head = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_octet(s[i]);
        end
    endtask

    task automatic send_size_line(input logic [31:0] size);
        int digits;
        digits = 8;
        while (digits > 1 && size[4*(digits-1) +: 4] == 4'd0) digits--;
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 2)) send_octet("0");
        end
        for (int i = digits - 1; i >= 0; i--) begin
            send_octet(hex_char(size[4*i +: 4], 1'($urandom_range(1))));
        end
        send_octet(CHAR_CR);
        send_octet(CHAR_LF);
    endtask

    task automatic send_chunk(input logic [31:0] size);
        send_size_line(size);
        repeat (size) send_octet(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) begin
            send_octet(8'($urandom_range(255)));
            send_octet(8'($urandom_range(255)));
        end else begin
            send_octet(CHAR_CR);
            send_octet(CHAR_LF);
        end
    endtask

    task automatic send_random_message();
        int          kind;
        logic [31:0] size;
        logic [7:0]  b;
        message_head = 1'b1;
        kind = $urandom_range(99);
        if (kind < 70) begin
            repeat ($urandom_range(3)) begin
                send_chunk(($urandom_range(9) == 0) ? $urandom_range(16, 48)
                                                    : $urandom_range(1, 8));
            end
            if ($urandom_range(4) == 0) begin
                send_octet(CHAR_CR);
                send_octet(CHAR_LF);
            end else begin
                send_size_line(32'd0);
            end
            repeat ($urandom_range(2)) send_octet(8'($urandom_range(255)));
        end else if (kind < 80) begin
            // stray byte inside a size line
            repeat ($urandom_range(2)) send_chunk($urandom_range(1, 8));
            repeat ($urandom_range(2)) begin
                send_octet(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            send_octet(junk_octet());
        end else if (kind < 85) begin
            // carriage return without line feed
            repeat ($urandom_range(1)) begin
                send_octet(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            send_octet(CHAR_CR);
            do begin
                b = 8'($urandom_range(255));
            end while (b == CHAR_LF);
            send_octet(b);
        end else if (kind < 90) begin
            // size wider than 32 bits
            send_octet(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
            repeat (8 + $urandom_range(1)) begin
                send_octet(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
        end else if (kind < 95) begin
            size = ($urandom_range(2) == 0) ? 32'hffff_ffff : ($urandom() | 32'h1000_0000);
            send_size_line(size);
            repeat ($urandom_range(1, 6)) send_octet(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int goal;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.start_message <= 1'b0;
        in_ch.octet_in      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 73;
        // empty size line
        message_head = 1'b1;
        send_octet(CHAR_CR);
        send_octet(CHAR_LF);
        // byte extremes, unchecked trailer, bytes after completion
        message_head = 1'b1;
        send_text("2\r\n");
        send_octet(8'h00);
        send_octet(8'hff);
        send_text("xy0\r\nZ");
        // whitespace, hex prefix, lone carriage return, size overflow
        message_head = 1'b1;
        send_text(" ");
        message_head = 1'b1;
        send_text("0x");
        message_head = 1'b1;
        send_text("\rA");
        message_head = 1'b1;
        send_text("100000000");

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                settle();
                write_limit(body_limits[(k + p) % 4]);
                goal = items_sent + 100;
                if (k == 1 && p != 1) begin
                    hold_requests = hold_requests + 1;
                end
                while (items_sent < goal) send_random_message();
            end
        end
        settle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/hcbd_pkg.sv
hdl/hcbd_if.sv
hdl/hcbd_in_reg.sv
hdl/hcbd_core.sv
hdl/hcbd_out_reg.sv
hdl/http_chunked_body_decoder_top.sv
hdl/hcbd_checker.sv
sim/hcbd_result_checker.sv
sim/http_chunked_body_decoder_top_test.sv
